@@ design/dfd_pkg.sv @@
// Package: shared types, codes and record-format tables of the detection frame deframer.
package dfd_pkg;

  localparam logic [7:0] START_MARK = 8'hAA;
  localparam logic [7:0] END_MARK   = 8'hBB;
  localparam logic [2:0] HEADER_LEN = 3'd5;
  localparam int         NUM_KINDS  = 4;
  localparam int         BUF_DEPTH  = 9;

  typedef enum logic [2:0] {
    KIND_OBJECT   = 3'd0,
    KIND_CROSSING = 3'd1,
    KIND_LIGHT    = 3'd2,
    KIND_STAIRS   = 3'd3,
    KIND_STATUS   = 3'd4
  } dfd_kind_e;

  // Parser state that is cleared at reset and at the end of each frame.
  typedef struct packed {
    logic [2:0]                 hdr_pos;
    logic                       start_ok;
    logic [NUM_KINDS-1:0][7:0]  counts;
    logic [NUM_KINDS-1:0][7:0]  accepted;
    logic                       rec_active;
    logic [1:0]                 rec_kind;
    logic [3:0]                 rec_pos;
  } dfd_state_t;

  // Write request into the record payload buffer.
  typedef struct packed {
    logic       en;
    logic [3:0] idx;
    logic [7:0] data;
  } dfd_buf_wr_t;

  typedef struct packed {
    logic [2:0]  item_kind;
    logic [7:0]  item_index;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] wide_value;
    logic [7:0]  byte_value;
    logic [7:0]  vertical_value;
    logic        frame_ok;
    logic        has_detections;
  } dfd_item_t;

  function automatic logic [7:0] tag_of(input logic [1:0] k);
    logic [7:0] t;
    case (k)
      2'd0:    t = 8'h1A;
      2'd1:    t = 8'h2A;
      2'd2:    t = 8'h3A;
      default: t = 8'h4A;
    endcase
    return t;
  endfunction

  function automatic logic [7:0] tail_of(input logic [1:0] k);
    logic [7:0] t;
    case (k)
      2'd0:    t = 8'h1B;
      2'd1:    t = 8'h2B;
      2'd2:    t = 8'h3B;
      default: t = 8'h4B;
    endcase
    return t;
  endfunction

  // Payload bytes between tag and tail.
  function automatic logic [3:0] payload_len(input logic [1:0] k);
    logic [3:0] n;
    case (k)
      2'd0:    n = 4'd9;
      2'd1:    n = 4'd6;
      default: n = 4'd5;
    endcase
    return n;
  endfunction

endpackage

@@ design/dfd_if.sv @@
// Interfaces: byte input channel and result item channel.
interface dfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       end_of_frame;

  modport source (output valid, output frame_byte, output end_of_frame, input ready);
  modport sink   (input valid, input frame_byte, input end_of_frame, output ready);
endinterface

interface dfd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  item_kind;
  logic [7:0]  item_index;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [15:0] wide_value;
  logic [7:0]  byte_value;
  logic [7:0]  vertical_value;
  logic        frame_ok;
  logic        has_detections;

  modport source (output valid, output item_kind, output item_index, output pos_x,
                  output pos_y, output wide_value, output byte_value,
                  output vertical_value, output frame_ok, output has_detections,
                  input ready);
  modport sink   (input valid, input item_kind, input item_index, input pos_x,
                  input pos_y, input wide_value, input byte_value,
                  input vertical_value, input frame_ok, input has_detections,
                  output ready);
endinterface

@@ design/dfd_parser.sv @@
// Parser: next-state and result logic for one frame byte.
module dfd_parser
  import dfd_pkg::*;
(
  input  dfd_state_t  st_i,
  input  logic [7:0]  rb_i [0:BUF_DEPTH-1],
  input  logic [7:0]  byte_i,
  input  logic        eof_i,
  output dfd_state_t  st_o,
  output dfd_buf_wr_t wr_o,
  output logic        got_o,
  output dfd_item_t   item_o
);

  logic [1:0] k;

  always_comb begin
    st_o   = st_i;
    wr_o   = '0;
    got_o  = 1'b0;
    item_o = '0;
    k      = st_i.rec_kind;

    if (st_i.hdr_pos < HEADER_LEN) begin
      if (st_i.hdr_pos == 3'd0) begin
        st_o.start_ok = (byte_i == START_MARK);
      end else begin
        st_o.counts[2'(st_i.hdr_pos - 3'd1)] = byte_i;
      end
      st_o.hdr_pos = st_i.hdr_pos + 3'd1;
    end else if (!st_i.rec_active) begin
      // tag search; tags are distinct so at most one kind matches
      for (int i = 0; i < NUM_KINDS; i++) begin
        if (byte_i == tag_of(2'(i)) && st_i.accepted[i] < st_i.counts[i]) begin
          st_o.rec_active = 1'b1;
          st_o.rec_kind   = 2'(i);
          st_o.rec_pos    = 4'd0;
        end
      end
    end else if (st_i.rec_pos < payload_len(k)) begin
      wr_o.en      = 1'b1;
      wr_o.idx     = st_i.rec_pos;
      wr_o.data    = byte_i;
      st_o.rec_pos = st_i.rec_pos + 4'd1;
    end else begin
      // tail slot: emit on match, drop otherwise
      st_o.rec_active = 1'b0;
      st_o.rec_pos    = 4'd0;
      if (byte_i == tail_of(k)) begin
        got_o             = 1'b1;
        item_o.item_kind  = {1'b0, k};
        item_o.item_index = st_i.accepted[k];
        item_o.pos_x      = {rb_i[0], rb_i[1]};
        item_o.pos_y      = {rb_i[2], rb_i[3]};
        case (k)
          2'd0: begin
            item_o.wide_value     = {rb_i[7], rb_i[8]};
            item_o.byte_value     = rb_i[5];
            item_o.vertical_value = rb_i[6];
          end
          2'd1: begin
            item_o.wide_value = {rb_i[4], rb_i[5]};
          end
          default: begin
            item_o.byte_value = rb_i[4];
          end
        endcase
        st_o.accepted[k] = st_i.accepted[k] + 8'd1;
      end
    end

    if (eof_i) begin
      got_o                 = 1'b1;
      item_o                = '0;
      item_o.item_kind      = KIND_STATUS;
      item_o.frame_ok       = st_o.start_ok && (byte_i == END_MARK);
      item_o.has_detections = |st_o.counts;
      st_o                  = '0;
    end
  end

endmodule

@@ design/detection_frame_deframer.sv @@
// Top level: detection frame deframer with input stage, parser and result register.
// Path: a byte transferred in waits in the input stage; its result (if any) is registered in the result register.
// Throughput: one byte per cycle, sustained while the result side takes items.
// Both stages move together; the input stage is refilled in the same cycle it drains.
// Reset: asynchronous, active low; clears handshake flags and all per-frame parser state.
// The nine-byte record buffer has no reset; every entry is written before it is read.
module detection_frame_deframer
  import dfd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  dfd_in_if.sink          in_i,
  dfd_out_if.source       out_o
);

  // Input stage
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_eof_q;

  // Parser state and record buffer
  dfd_state_t st_q, st_d;
  logic [7:0] rb_q [0:BUF_DEPTH-1];
  dfd_buf_wr_t wr;

  // Result register
  logic      out_valid_q;
  dfd_item_t out_q;
  dfd_item_t item_d;
  logic      got_d;

  logic advance;   // input stage byte is consumed by the parser this cycle
  logic in_xfer;

  // The input stage drains whenever the result register is free or being taken.
  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_xfer    = in_i.valid && in_i.ready;

  dfd_parser u_parser (
    .st_i   (st_q),
    .rb_i   (rb_q),
    .byte_i (s1_byte_q),
    .eof_i  (s1_eof_q),
    .st_o   (st_d),
    .wr_o   (wr),
    .got_o  (got_d),
    .item_o (item_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_byte_q <= in_i.frame_byte;
      s1_eof_q  <= in_i.end_of_frame;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // Record payload buffer: one write port, fixed read taps in the parser.
  always_ff @(posedge clk_i) begin
    if (advance && wr.en) begin
      rb_q[wr.idx] <= wr.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= got_d;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && got_d) begin
      out_q <= item_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.item_kind      = out_q.item_kind;
  assign out_o.item_index     = out_q.item_index;
  assign out_o.pos_x          = out_q.pos_x;
  assign out_o.pos_y          = out_q.pos_y;
  assign out_o.wide_value     = out_q.wide_value;
  assign out_o.byte_value     = out_q.byte_value;
  assign out_o.vertical_value = out_q.vertical_value;
  assign out_o.frame_ok       = out_q.frame_ok;
  assign out_o.has_detections = out_q.has_detections;

  // A frame end always yields a status item and leaves the parser cleared.
  a_eof_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_eof_q |=> out_valid_q && out_q.item_kind == KIND_STATUS
      && st_q.hdr_pos == 3'd0 && !st_q.rec_active)
    else $error("frame end did not produce a status item and a cleared parser");

  // Records are only collected after the full header.
  a_rec_after_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.rec_active |-> st_q.hdr_pos == HEADER_LEN)
    else $error("record active before header complete");

  // Payload position never runs past the record's length, and idles at zero.
  a_rec_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.rec_active && st_q.rec_pos <= payload_len(st_q.rec_kind))
      || (!st_q.rec_active && st_q.rec_pos == 4'd0))
    else $error("record position out of range");

  // A record item never reports an ordinal at or above its header count.
  a_rec_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && got_d && !s1_eof_q |->
      item_d.item_index < st_q.counts[st_q.rec_kind])
    else $error("record emitted beyond header count");

endmodule
